// ===== design/cse_pkg.sv =====
// Shared types, constants and helpers for the C string escape encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package cse_pkg;

  localparam int QueueDepth = 2;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 32;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChZero      = 8'h30;

  localparam logic [CfgAddrW-1:0] RegHexEscapes = CfgAddrW'(0);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       keep_utf8;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // One classified byte: up to four output bytes and the index of the last one.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } run_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h61 + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

  function automatic logic is_hex_digit(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

endpackage
`default_nettype wire

// ===== design/cse_front.sv =====
// Front end: accepts source bytes, classifies them and builds the escape run.
// Depends on cse_pkg; keeps the remembered hex-escape flag.
`default_nettype none
module cse_front
  import cse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic hex_escapes,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      push,
  output run_t      push_run
);

  logic prev_hex_r, prev_hex_nxt;
  logic [7:0] b;
  logic [7:0] second;
  logic printable, escape, now_hex;

  assign b        = in_data.data_byte;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    case (b)
      8'h0A:   second = 8'h6E;
      8'h0D:   second = 8'h72;
      8'h09:   second = 8'h74;
      8'h22:   second = 8'h22;
      8'h27:   second = 8'h27;
      8'h5C:   second = 8'h5C;
      default: second = 8'h00;
    endcase
  end

  always_comb begin
    printable = (b >= 8'h20) && (b <= 8'h7E);
    escape    = (!in_data.keep_utf8 || !b[7]) &&
                (!printable || (prev_hex_r && is_hex_digit(b)));
    now_hex   = 1'b0;
    push_run  = '0;
    if (second != 8'h00) begin
      push_run.bytes[0] = ChBackslash;
      push_run.bytes[1] = second;
      push_run.last_idx = 2'd1;
    end else if (escape) begin
      push_run.bytes[0] = ChBackslash;
      push_run.last_idx = 2'd3;
      if (hex_escapes) begin
        push_run.bytes[1] = ChX;
        push_run.bytes[2] = hex_char(b[7:4]);
        push_run.bytes[3] = hex_char(b[3:0]);
        now_hex = 1'b1;
      end else begin
        push_run.bytes[1] = ChZero + {6'd0, b[7:6]};
        push_run.bytes[2] = ChZero + {5'd0, b[5:3]};
        push_run.bytes[3] = ChZero + {5'd0, b[2:0]};
      end
    end else begin
      push_run.bytes[0] = b;
      push_run.last_idx = 2'd0;
    end
  end

  assign prev_hex_nxt = push ? (now_hex && !in_data.string_end) : prev_hex_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_hex_r <= 1'b0;
    end else begin
      prev_hex_r <= prev_hex_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/cse_queue.sv =====
// Short request queue between the front and back ends.
// Depends on cse_pkg for the run type.
`default_nettype none
module cse_queue
  import cse_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire run_t push_run,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output run_t      head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  run_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full  = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= advance(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= advance(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/cse_back.sv =====
// Back end: serializes each queued run, one byte per unstalled cycle.
// Depends on cse_pkg; drives the registered output channel.
`default_nettype none
module cse_back
  import cse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire run_t q_head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;
  logic       load, is_last;

  assign load    = !q_empty && (!out_valid_r || !out_stall);
  assign is_last = (idx_r == q_head.last_idx);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = q_head.bytes[idx_r];
      out_data_nxt.last_of_run = is_last;
      idx_nxt                  = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== design/c_string_escape_encoder_top.sv =====
// Top level of the C string escape encoder: configuration port and wiring.
// Depends on cse_pkg, cse_front, cse_queue and cse_back.
//
// Each input byte yields one to four output bytes, the last marked with
// last_of_run: one byte for plain characters, two for backslash escapes, four
// for octal or hex escapes. The output serializer emits one byte per cycle
// while out_stall is low; plain text then streams at one byte per cycle.
// The input is taken while the run queue has room, so the front end keeps
// classifying while the back end still drains earlier escapes. The user must
// write register hex_escapes at address 0 (bit 0) only while idle; unenforced.
`default_nettype none
module c_string_escape_encoder_top
  import cse_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_t                 in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_t                     out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0]      cfg_prdata,
  output logic                     cfg_pready
);

  logic hex_r, hex_nxt;
  logic q_full, q_empty, push, pop;
  run_t push_run, q_head;
  logic reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CfgAddrW-1:2] == RegHexEscapes[CfgAddrW-1:2]);
  assign hex_nxt    = (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) ?
                      cfg_pwdata[0] : hex_r;
  assign cfg_prdata = reg_sel ? {{(CfgDataW-1){1'b0}}, hex_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_r <= 1'b0;
    end else begin
      hex_r <= hex_nxt;
    end
  end

  cse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .hex_escapes(hex_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_run   (push_run)
  );

  cse_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_run(push_run),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (q_head)
  );

  cse_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
